// ===== src/rqd_pkg.sv =====
// Shared widths, register indexes and structs for the ray/ellipsoid depth solver.
package rqd_pkg;

  localparam int XW    = 19;   // screen coordinate, Q2.16
  localparam int CFW   = 32;   // one coefficient, Q16.16
  localparam int CFGW  = 64;
  localparam int IDXW  = 3;
  localparam int DEPW  = 18;
  localparam int PXW   = CFW + XW;   // coefficient times coordinate
  localparam int BW    = 53;         // B, U, V
  localparam int FW    = BW - 16;    // floor(U / 2^16)
  localparam int PCW   = FW + XW;
  localparam int CW    = 57;         // C
  localparam int MBW   = 52;         // |B|
  localparam int HBW   = MBW / 2;
  localparam int MCW   = 56;         // |C|
  localparam int HCW   = MCW / 2;
  localparam int DW    = 108;        // discriminant
  localparam int RW    = DW / 2;     // square root
  localparam int RMW   = RW + 2;     // root remainder
  localparam int NW    = 58;         // numerator, signed
  localparam int NMW   = NW - 1;
  localparam int DENW  = CFW + 1;    // 2|a|
  localparam int QB    = 17;         // quotient bits kept
  localparam int RDW   = DENW + QB;  // divider remainder
  localparam logic [QB-1:0] ONE_Q16 = QB'(65536);

  localparam logic [IDXW-1:0] REG_ZZ_ZX    = 3'd0;
  localparam logic [IDXW-1:0] REG_ZY_Z1    = 3'd1;
  localparam logic [IDXW-1:0] REG_XX_XY    = 3'd2;
  localparam logic [IDXW-1:0] REG_X1_YY    = 3'd3;
  localparam logic [IDXW-1:0] REG_Y1_CONST = 3'd4;

  typedef struct packed {
    logic signed [CFW-1:0] zz;
    logic signed [CFW-1:0] zx;
    logic signed [CFW-1:0] zy;
    logic signed [CFW-1:0] z1;
    logic signed [CFW-1:0] xx;
    logic signed [CFW-1:0] xy;
    logic signed [CFW-1:0] x1;
    logic signed [CFW-1:0] yy;
    logic signed [CFW-1:0] y1;
    logic signed [CFW-1:0] k;
  } coef_t;

  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic signed [BW-1:0] b;
    logic [DW-1:0]        delta;
  } disc_t;

  typedef struct packed {
    logic                 valid;
    logic                 miss;
    logic signed [BW-1:0] b;
    logic [RW-1:0]        s;
  } root_t;

endpackage

// ===== src/rqd_if.sv =====
// Request channels: screen coordinates in, hit and depth out.
interface rqd_in_if import rqd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] screen_x;
  logic signed [XW-1:0] screen_y;
  modport source(output valid, screen_x, screen_y, input ready);
  modport sink(input valid, screen_x, screen_y, output ready);
endinterface

interface rqd_out_if import rqd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [DEPW-1:0] depth;
  modport source(output valid, hit, depth, input ready);
  modport sink(input valid, hit, depth, output ready);
endinterface

// ===== src/rqd_front.sv =====
// Quadratic coefficients B and C and the discriminant, seven stages.
module rqd_front import rqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  coef_t                coef,
  output disc_t                disc
);

  logic [7:1] v_r;

  logic signed [PXW-1:0] pzx1_r, pzy1_r, pxx1_r, pxy1_r, pyy1_r;
  logic signed [XW-1:0]  sx1_r, sy1_r, sx2_r, sy2_r;
  logic signed [BW-1:0]  b2_r, u2_r, v2_r, b3_r, b4_r, b5_r, b6_r, b7_r;
  logic signed [FW-1:0]  fu, fv;
  logic signed [PCW-1:0] pcx3_r, pcy3_r;
  logic signed [CW-1:0]  c4_r;
  logic [MBW-1:0]        magb;
  logic [MCW-1:0]        magc;
  logic [CFW-1:0]        maga;
  logic [2*HBW-1:0]      hh5_r, hl5_r, ll5_r;
  logic [CFW+HCW-1:0]    qh5_r, ql5_r;
  logic                  qneg5_r, qneg6_r, az5_r, az6_r, miss7_r;
  logic [DW-1:0]         p6_r, q6_r, delta7_r;

  assign fu   = u2_r[BW-1:16];
  assign fv   = v2_r[BW-1:16];
  assign magb = b4_r[BW-1] ? MBW'(-b4_r) : MBW'(b4_r);
  assign magc = c4_r[CW-1] ? MCW'(-c4_r) : MCW'(c4_r);
  assign maga = coef.zz[CFW-1] ? CFW'(-coef.zz) : CFW'(coef.zz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: coordinate products
      pzx1_r <= signed'(coef.zx) * in_x;
      pzy1_r <= signed'(coef.zy) * in_y;
      pxx1_r <= signed'(coef.xx) * in_x;
      pxy1_r <= signed'(coef.xy) * in_y;
      pyy1_r <= signed'(coef.yy) * in_y;
      sx1_r  <= in_x;
      sy1_r  <= in_y;
      // stage 2: B, U, V
      b2_r  <= BW'(pzx1_r) + BW'(pzy1_r) + BW'(signed'({coef.z1, 16'h0}));
      u2_r  <= BW'(pxx1_r) + BW'(pxy1_r) + BW'(signed'({coef.x1, 16'h0}));
      v2_r  <= BW'(pyy1_r) + BW'(signed'({coef.y1, 16'h0}));
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      // stage 3: floored U, V times coordinates
      pcx3_r <= fu * sx2_r;
      pcy3_r <= fv * sy2_r;
      b3_r   <= b2_r;
      // stage 4: C
      c4_r <= CW'(pcx3_r) + CW'(pcy3_r) + CW'(signed'({coef.k, 16'h0}));
      b4_r <= b3_r;
      // stage 5: partial products of B^2 and |a||C|
      hh5_r   <= magb[MBW-1:HBW] * magb[MBW-1:HBW];
      hl5_r   <= magb[MBW-1:HBW] * magb[HBW-1:0];
      ll5_r   <= magb[HBW-1:0] * magb[HBW-1:0];
      qh5_r   <= maga * magc[MCW-1:HCW];
      ql5_r   <= maga * magc[HCW-1:0];
      qneg5_r <= (c4_r != '0) && (coef.zz[CFW-1] != c4_r[CW-1]);
      az5_r   <= (coef.zz == '0);
      b5_r    <= b4_r;
      // stage 6: B^2 and 4ac scaled to Q.64
      p6_r    <= (DW'(hh5_r) << (2*HBW)) + (DW'(hl5_r) << (HBW+1)) + DW'(ll5_r);
      q6_r    <= (DW'(qh5_r) << (HCW+18)) + (DW'(ql5_r) << 18);
      qneg6_r <= qneg5_r;
      az6_r   <= az5_r;
      b6_r    <= b5_r;
      // stage 7: discriminant and miss
      miss7_r  <= az6_r || (!qneg6_r && (p6_r <= q6_r));
      delta7_r <= qneg6_r ? (p6_r + q6_r) : (p6_r - q6_r);
      b7_r     <= b6_r;
    end
  end

  assign disc.valid = v_r[7];
  assign disc.miss  = miss7_r;
  assign disc.b     = b7_r;
  assign disc.delta = delta7_r;

endmodule

// ===== src/rqd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rqd_sqrt import rqd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  disc_t disc,
  output root_t root
);

  logic [RW:0]          v_r;
  logic                 miss_r [0:RW];
  logic signed [BW-1:0] b_r    [0:RW];
  logic [DW-1:0]        rad_r  [0:RW];
  logic [RMW-1:0]       rem_r  [0:RW];
  logic [RW-1:0]        rt_r   [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RW-1:0], disc.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss_r[0] <= disc.miss;
      b_r[0]    <= disc.b;
      rad_r[0]  <= disc.delta;
      rem_r[0]  <= '0;
      rt_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RMW+1:0] t, trial;
    logic           ge;
    assign t     = {rem_r[i], rad_r[i][DW-1 -: 2]};
    assign trial = (RMW+2)'({rt_r[i], 2'b01});
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        miss_r[i+1] <= miss_r[i];
        b_r[i+1]    <= b_r[i];
        rad_r[i+1]  <= rad_r[i] << 2;
        rem_r[i+1]  <= ge ? RMW'(t - trial) : RMW'(t);
        rt_r[i+1]   <= {rt_r[i][RW-2:0], ge};
      end
    end
  end

  assign root.valid = v_r[RW];
  assign root.miss  = miss_r[RW];
  assign root.b     = b_r[RW];
  assign root.s     = rt_r[RW];

endmodule

// ===== src/rqd_div.sv =====
// Numerator, pipelined restoring divide by 2a, range check and output register.
module rqd_div import rqd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  root_t                  root,
  input  logic signed [CFW-1:0]  coef_a,
  output logic                   res_valid,
  output logic                   res_hit,
  output logic signed [DEPW-1:0] res_depth
);

  logic signed [NW-1:0] num;
  logic [NMW-1:0]       magn;
  logic [DENW-1:0]      den;

  logic [QB:0]     v_r;
  logic            miss_r [0:QB];
  logic            neg_r  [0:QB];
  logic [DENW-1:0] den_r  [0:QB];
  logic [RDW-1:0]  rem_r  [0:QB];
  logic [QB-1:0]   q_r    [0:QB];
  logic            out_v_r, hit_r;
  logic signed [DEPW-1:0] depth_r;
  logic            hit_nxt;

  assign num  = -NW'(root.b) - NW'(root.s);
  assign magn = num[NW-1] ? NMW'(-num) : NMW'(num);
  assign den  = {(coef_a[CFW-1] ? CFW'(-coef_a) : CFW'(coef_a)), 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[QB-1:0], root.valid};
      out_v_r <= v_r[QB];
    end
  end

  // quotient at or above 2^17 is out of range anyway
  always_ff @(posedge clk) begin
    if (en) begin
      miss_r[0] <= root.miss || (magn >= NMW'({den, {QB{1'b0}}}));
      neg_r[0]  <= num[NW-1] ^ coef_a[CFW-1];
      den_r[0]  <= den;
      rem_r[0]  <= RDW'(magn);
      q_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [RDW-1:0] dsh;
    logic           ge;
    assign dsh = RDW'(den_r[i]) << (QB-1-i);
    assign ge  = (rem_r[i] >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        miss_r[i+1] <= miss_r[i];
        neg_r[i+1]  <= neg_r[i];
        den_r[i+1]  <= den_r[i];
        rem_r[i+1]  <= ge ? (rem_r[i] - dsh) : rem_r[i];
        q_r[i+1]    <= {q_r[i][QB-2:0], ge};
      end
    end
  end

  assign hit_nxt = !miss_r[QB] && (q_r[QB] <= ONE_Q16);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      if (!hit_nxt) begin
        depth_r <= '0;
      end else if (neg_r[QB]) begin
        depth_r <= -DEPW'(q_r[QB]);
      end else begin
        depth_r <= DEPW'(q_r[QB]);
      end
    end
  end

  assign res_valid = out_v_r;
  assign res_hit   = hit_r;
  assign res_depth = depth_r;

endmodule

// ===== src/ray_ellipsoid_depth.sv =====
// Top level: coefficient registers and the depth pipeline.
//
//   channel  | dir | fields                     | accepted when
//   ---------+-----+----------------------------+------------------------
//   in_if    | in  | screen_x, screen_y (Q2.16) | valid && ready
//   out_if   | out | hit, depth (Q1.16)         | valid && ready
//   cfg_*    | in  | cfg_idx, cfg_data          | cfg_we
//
// One request per cycle while the pipeline is not held; requests pass
// 7 front-end, 55 square-root and 19 divide and output stages.
// The whole pipeline advances together; it holds while the output register
// is full and not taken, and in_if.ready is low only then.
// Synchronous reset clears the valid bits and the coefficients.
module ray_ellipsoid_depth import rqd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rqd_in_if.sink            in_if,
  rqd_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [IDXW-1:0]   cfg_idx,
  input  logic [CFGW-1:0]   cfg_data
);

  logic [CFGW-1:0] zz_zx_r, zy_z1_r, xx_xy_r, x1_yy_r, y1_k_r;
  coef_t coef;
  disc_t disc;
  root_t root;
  logic  en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zz_zx_r <= '0;
      zy_z1_r <= '0;
      xx_xy_r <= '0;
      x1_yy_r <= '0;
      y1_k_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ZZ_ZX:    zz_zx_r <= cfg_data;
        REG_ZY_Z1:    zy_z1_r <= cfg_data;
        REG_XX_XY:    xx_xy_r <= cfg_data;
        REG_X1_YY:    x1_yy_r <= cfg_data;
        REG_Y1_CONST: y1_k_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef.zz = zz_zx_r[63:32];
  assign coef.zx = zz_zx_r[31:0];
  assign coef.zy = zy_z1_r[63:32];
  assign coef.z1 = zy_z1_r[31:0];
  assign coef.xx = xx_xy_r[63:32];
  assign coef.xy = xx_xy_r[31:0];
  assign coef.x1 = x1_yy_r[63:32];
  assign coef.yy = x1_yy_r[31:0];
  assign coef.y1 = y1_k_r[63:32];
  assign coef.k  = y1_k_r[31:0];

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  rqd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_if.valid),
    .in_x     (in_if.screen_x),
    .in_y     (in_if.screen_y),
    .coef     (coef),
    .disc     (disc)
  );

  rqd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .disc  (disc),
    .root  (root)
  );

  rqd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .root      (root),
    .coef_a    (coef.zz),
    .res_valid (out_if.valid),
    .res_hit   (out_if.hit),
    .res_depth (out_if.depth)
  );

endmodule

// ===== src/rqd_checker.sv =====
// Port-level checks on the depth solver, bound to the top level.
module rqd_assert import rqd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_hit,
  input logic signed [DEPW-1:0] out_depth
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while output stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) && $stable(out_depth)))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_depth == '0))
    else $error("miss with nonzero depth");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_depth >= -18'sd65536 && out_depth <= 18'sd65536))
    else $error("hit depth outside [-1, 1]");

endmodule

bind ray_ellipsoid_depth rqd_assert u_rqd_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_hit   (out_if.hit),
  .out_depth (out_if.depth)
);

// ===== test/rqd_checker.sv =====
// Checker: mirrors the coefficients, predicts hit/depth per request, compares results.
`timescale 1ns / 1ps
module rqd_checker import rqd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rqd_in_if               in_if,
  rqd_out_if              out_if,
  input  logic            cfg_we,
  input  logic [IDXW-1:0] cfg_idx,
  input  logic [CFGW-1:0] cfg_data,
  output int              fail_count,
  output int              pending,
  output int              req_count
);

  typedef struct packed {
    logic                   hit;
    logic signed [DEPW-1:0] depth;
  } depth_res_t;

  coef_t      quad;
  depth_res_t depth_q[$];

  function automatic longint unsigned floor_sqrt(logic [127:0] n);
    longint unsigned r;
    longint unsigned t;
    logic [127:0]    tt;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      t  = r | (64'd1 << i);
      tt = t;
      if (tt * tt <= n) r = t;
    end
    return r;
  endfunction

  function automatic depth_res_t solve_depth(logic signed [XW-1:0] sx,
                                             logic signed [XW-1:0] sy);
    depth_res_t         res;
    longint             x, y, a, b, u, v, c, num, z;
    logic signed [127:0] bw, aw, cw, disc;
    x = sx;
    y = sy;
    a = quad.zz;
    res = '0;
    if (a == 0) return res;
    b = longint'(quad.zx) * x + longint'(quad.zy) * y + longint'(quad.z1) * 65536;
    u = longint'(quad.xx) * x + longint'(quad.xy) * y + longint'(quad.x1) * 65536;
    v = longint'(quad.yy) * y + longint'(quad.y1) * 65536;
    // arithmetic shift gives the floor toward minus infinity
    c = (u >>> 16) * x + (v >>> 16) * y + longint'(quad.k) * 65536;
    bw = b;
    aw = a;
    cw = c;
    disc = bw * bw - aw * cw * 262144;
    if (disc <= 0) return res;
    num = -b - longint'(floor_sqrt(disc));
    z = num / (2 * a);
    if (z < -65536 || z > 65536) return res;
    res.hit   = 1'b1;
    res.depth = z[DEPW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    depth_res_t got, want;
    if (!rst_n) begin
      quad       <= '0;
      fail_count <= 0;
      req_count  <= 0;
      pending    <= 0;
      depth_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ZZ_ZX:    {quad.zz, quad.zx} <= cfg_data;
          REG_ZY_Z1:    {quad.zy, quad.z1} <= cfg_data;
          REG_XX_XY:    {quad.xx, quad.xy} <= cfg_data;
          REG_X1_YY:    {quad.x1, quad.yy} <= cfg_data;
          REG_Y1_CONST: {quad.y1, quad.k}  <= cfg_data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        depth_q.push_back(solve_depth(in_if.screen_x, in_if.screen_y));
        req_count <= req_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got.hit   = out_if.hit;
        got.depth = out_if.depth;
        if (depth_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result hit=%0b depth=%0d", got.hit, got.depth);
          fail_count <= fail_count + 1;
        end else begin
          want = depth_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected hit=%0b depth=%0d, got hit=%0b depth=%0d",
                       want.hit, want.depth, got.hit, got.depth);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= depth_q.size();
    end
  end

endmodule

// ===== test/tb_ray_ellipsoid_depth.sv =====
// Testbench top: clock, reset, coefficient setups, request traffic and verdict.
`timescale 1ns / 1ps
module tb_ray_ellipsoid_depth import rqd_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_REQS  = 192;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [IDXW-1:0] cfg_idx;
  logic [CFGW-1:0] cfg_data;
  int              fail_count, pending, req_count;
  int              sent;
  int              cycles;
  logic            hold_off;

  rqd_in_if  in_if ();
  rqd_out_if out_if ();

  ray_ellipsoid_depth dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  rqd_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .req_count(req_count)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // idle percentages: sender-light, then receiver-light, then none
  function automatic int send_idle_pct();
    return (sent < 383) ? 16 : (sent < 766) ? 86 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (sent < 383) ? 86 : (sent < 766) ? 16 : 0;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct());
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    hold_off = 1'b0;
    wait (sent >= 850);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ray_ellipsoid_depth: FAIL");
      $finish;
    end
  end

  task automatic write_coef(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stop offering requests and wait until every result has left
  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic load_quadric(input logic [CFGW-1:0] r0, r1, r2, r3, r4);
    drain();
    write_coef(REG_ZZ_ZX, r0);
    write_coef(REG_ZY_Z1, r1);
    write_coef(REG_XX_XY, r2);
    write_coef(REG_X1_YY, r3);
    write_coef(REG_Y1_CONST, r4);
  endtask

  task automatic send_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.screen_x <= x;
    in_if.screen_y <= y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] small_coef(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [XW-1:0] rand_coord();
    // mostly inside the unit screen, sometimes the full range
    if ($urandom_range(3) == 0) return XW'($urandom);
    return XW'($signed($urandom_range(131072)) - 65536);
  endfunction

  task automatic random_quadric(input int kind);
    logic [31:0] zz, xx, yy, k;
    zz = $urandom_range(262144, 8192);
    xx = $urandom_range(262144, 8192);
    yy = $urandom_range(262144, 8192);
    k  = -$urandom_range(65536, 1024);
    case (kind)
      0: load_quadric({zz, small_coef(32768)}, {small_coef(32768), small_coef(65536)},
                      {xx, small_coef(32768)}, {small_coef(65536), yy},
                      {small_coef(65536), k});
      // a < 0: zz, xx, yy and k negated, the other coefficients random as in kind 0
      1: load_quadric({-zz, small_coef(32768)}, {small_coef(32768), small_coef(65536)},
                      {-xx, small_coef(32768)}, {small_coef(65536), -yy},
                      {small_coef(65536), -k});
      2: load_quadric({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      3: load_quadric({32'h8000_0000, 32'h7fff_ffff}, {32'h8000_0000, 32'h8000_0000},
                      {32'h7fff_ffff, 32'h8000_0000}, {32'h7fff_ffff, 32'h7fff_ffff},
                      {32'h8000_0000, 32'h7fff_ffff});
      4: load_quadric({32'h7fff_ffff, 32'hffff_ffff}, {32'hffff_ffff, 32'hffff_ffff},
                      {32'hffff_ffff, 32'h7fff_ffff}, {32'h8000_0000, 32'hffff_ffff},
                      {32'h7fff_ffff, 32'h8000_0000});
      default: load_quadric({32'd0, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
    endcase
  endtask

  initial begin
    int kind;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.screen_x = '0;
    in_if.screen_y = '0;
    sent           = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // all coefficients zero after reset: zero a is a miss
    send_pixel('0, '0);
    // unit-radius-half sphere at the origin
    load_quadric({32'sd65536, 32'd0}, 64'd0, {32'sd65536, 32'd0},
                 {32'd0, 32'sd65536}, {32'd0, -32'sd16384});
    send_pixel('0, '0);                       // hit at -0.5
    send_pixel(XW'(32768), '0);               // tangent: zero discriminant
    send_pixel('0, XW'(-32768));
    send_pixel(XW'(16384), XW'(-16384));
    send_pixel(XW'(-262144), XW'(-262144));   // field extremes
    send_pixel(XW'(262143), XW'(262143));
    send_pixel(XW'(-262144), XW'(262143));
    send_pixel(XW'(1), XW'(-1));
    // out-of-range indexes must be ignored
    drain();
    write_coef(IDXW'(5), '1);
    write_coef(IDXW'(7), '1);
    send_pixel(XW'(8192), XW'(8192));
    // same sphere shifted to depth 2: nearer root 1.5 is out of range
    load_quadric({32'sd65536, 32'd0}, {32'd0, -32'sd262144}, {32'sd65536, 32'd0},
                 {32'd0, 32'sd65536}, {32'd0, 32'sd245760});
    send_pixel('0, '0);
    send_pixel(XW'(4096), XW'(4096));
    // shifted to depth 1 with a < 0: the root taken is 1.5, a miss; edge near +1
    load_quadric({-32'sd65536, 32'd0}, {32'd0, 32'sd131072}, {-32'sd65536, 32'd0},
                 {32'd0, -32'sd65536}, {32'd0, -32'sd49152});
    send_pixel('0, '0);
    send_pixel(XW'(30000), XW'(-20000));
    send_pixel(XW'(32767), '0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = (p < 2) ? p : $urandom_range(5);
      if (p == RAND_PHASES - 1) kind = 0;
      random_quadric(kind);
      for (int i = 0; i < PHASE_REQS; i++) send_pixel(rand_coord(), rand_coord());
    end
    random_quadric(3);
    send_pixel(XW'(-262144), XW'(262143));
    send_pixel(XW'(262143), XW'(-262144));
    random_quadric(4);
    send_pixel(XW'(-262144), XW'(-262144));
    send_pixel(XW'(262143), XW'(262143));
    in_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && req_count == sent) $display("tb_ray_ellipsoid_depth: PASS");
    else $display("tb_ray_ellipsoid_depth: FAIL");
    $finish;
  end

endmodule
